[rtl/hlfd_pkg.sv]
// Shared types and constants of the header/length frame deframer.
// Used by the front parser, the command queue, the result sequencer and the top level.
`default_nettype none

package hlfd_pkg;

   localparam int BUF_SIZE_DEFAULT    = 128;
   localparam int FRAME_CAP_DEFAULT   = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] SYNC_FIRST  = 8'h5A;
   localparam logic [7:0] SYNC_SECOND = 8'hA5;
   localparam logic [8:0] HEADER_LEN  = 9'd3;

   // One command from the parser: either a whole header (three results built
   // from the length byte) or a single frame byte with its position.
   typedef struct packed {
      logic       is_header;
      logic [7:0] data;
      logic [7:0] pos;
      logic       last;
   } hlfd_cmd_type;

endpackage

`default_nettype wire

[rtl/hlfd_front.sv]
// Front parser: sync hunt, length check and byte counting.
// Depends on hlfd_pkg; emits hlfd_cmd_type commands into the queue.
`default_nettype none

module hlfd_front #(
   parameter int BUF_SIZE = hlfd_pkg::BUF_SIZE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  restart,
   output logic                       push,
   output hlfd_pkg::hlfd_cmd_type     cmd
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_LEN,
      PH_DATA
   } phase_type;

   localparam logic [8:0] MAX_LEN = 9'(BUF_SIZE - 3);

   phase_type  phase_ff, phase_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] total_ff, total_in;
   logic [8:0] count_next;
   logic       last;
   logic       len_ok;

   assign count_next = count_ff + 9'd1;
   assign last       = (count_next >= total_ff);
   assign len_ok     = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= MAX_LEN);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      push          = 1'b0;
      cmd.is_header = 1'b0;
      cmd.data      = rx_byte;
      cmd.pos       = count_ff[7:0];
      cmd.last      = 1'b0;
      if (accept) begin
         if (restart) begin
            phase_in = PH_HUNT;
            count_in = 9'd0;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (rx_byte == hlfd_pkg::SYNC_FIRST) begin
                     phase_in = PH_SYNC2;
                     count_in = 9'd1;
                  end
               end
               PH_SYNC2: begin
                  if (rx_byte == hlfd_pkg::SYNC_SECOND) begin
                     phase_in = PH_LEN;
                     count_in = 9'd2;
                  end else if (rx_byte == hlfd_pkg::SYNC_FIRST) begin
                     count_in = 9'd1;
                  end else begin
                     phase_in = PH_HUNT;
                     count_in = 9'd0;
                  end
               end
               PH_LEN: begin
                  if (len_ok) begin
                     phase_in      = PH_DATA;
                     count_in      = hlfd_pkg::HEADER_LEN;
                     total_in      = hlfd_pkg::HEADER_LEN + {1'b0, rx_byte};
                     push          = 1'b1;
                     cmd.is_header = 1'b1;
                  end else begin
                     phase_in = PH_HUNT;
                     count_in = 9'd0;
                  end
               end
               default: begin
                  push     = 1'b1;
                  cmd.last = last;
                  if (last) begin
                     phase_in = PH_HUNT;
                     count_in = 9'd0;
                  end else begin
                     count_in = count_next;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= 9'd0;
         total_ff <= 9'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

[rtl/hlfd_queue.sv]
// Short command queue between the parser and the result sequencer.
// Depends on hlfd_pkg for the command type; flip-flop storage, one read port.
`default_nettype none

module hlfd_queue #(
   parameter int DEPTH = hlfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire hlfd_pkg::hlfd_cmd_type push_cmd,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       not_empty,
   output hlfd_pkg::hlfd_cmd_type     head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   hlfd_pkg::hlfd_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/hlfd_back.sv]
// Result sequencer: expands header commands into three results and drives
// the output register. Depends on hlfd_pkg.
`default_nettype none

module hlfd_back #(
   parameter int FRAME_CAP = hlfd_pkg::FRAME_CAP_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire hlfd_pkg::hlfd_cmd_type cmd,
   output logic                       cmd_pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [7:0]                 out_byte,
   output logic [7:0]                 out_pos,
   output logic                       out_last,
   output logic                       out_cap
);

   localparam logic [8:0] CAP = 9'(FRAME_CAP);

   logic       valid_ff, valid_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] pos_ff, pos_in;
   logic       last_ff, last_in;
   logic       cap_ff, cap_in;
   logic       load;
   logic [7:0] sel_byte;
   logic [7:0] sel_pos;
   logic       sel_cap;

   assign load = cmd_valid && (!valid_ff || out_ready);

   always_comb begin
      if (cmd.is_header) begin
         sel_pos = {6'd0, sub_ff};
         case (sub_ff)
            2'd0:    sel_byte = hlfd_pkg::SYNC_FIRST;
            2'd1:    sel_byte = hlfd_pkg::SYNC_SECOND;
            default: sel_byte = cmd.data;
         endcase
      end else begin
         sel_pos  = cmd.pos;
         sel_byte = cmd.data;
      end
      sel_cap = ({1'b0, sel_pos} >= CAP);
   end

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      byte_in  = byte_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      cap_in   = cap_ff;
      cmd_pop  = 1'b0;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_cap ? 8'd0 : sel_byte;
         pos_in   = sel_pos;
         last_in  = cmd.is_header ? 1'b0 : cmd.last;
         cap_in   = sel_cap;
         // A header command stays at the head until its third byte is out.
         if (cmd.is_header && sub_ff != 2'd2) begin
            sub_in = sub_ff + 2'd1;
         end else begin
            sub_in  = 2'd0;
            cmd_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
      byte_ff <= byte_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
      cap_ff  <= cap_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_pos   = pos_ff;
   assign out_last  = last_ff;
   assign out_cap   = cap_ff;

endmodule

`default_nettype wire

[rtl/header_length_frame_deframer.sv]
// Sync/length frame deframer, streaming. An accepted length or payload byte is pushed into
// the command queue as a command; the result sequencer loads results from the queue head
// into the output register. One byte per cycle in the sync hunt and the payload while the
// queue is not full; the length byte yields three results from the result sequencer, with a
// command queue absorbing the burst.
// Reset is synchronous and active high; it returns to the sync hunt and empties the queue.
`default_nettype none

module header_length_frame_deframer #(
   parameter int BUF_SIZE    = hlfd_pkg::BUF_SIZE_DEFAULT,
   parameter int FRAME_CAP   = hlfd_pkg::FRAME_CAP_DEFAULT,
   parameter int QUEUE_DEPTH = hlfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [15:8] byte_pos
   output logic             rsp_tlast,   // frame_last
   output logic [0:0]       rsp_tuser    // [0] beyond_cap
);

   hlfd_pkg::hlfd_cmd_type push_cmd;
   hlfd_pkg::hlfd_cmd_type head_cmd;
   logic push;
   logic pop;
   logic full;
   logic not_empty;
   logic accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   hlfd_front #(
      .BUF_SIZE (BUF_SIZE)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .restart (req_tuser[0]),
      .push    (push),
      .cmd     (push_cmd)
   );

   hlfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head_cmd)
   );

   hlfd_back #(
      .FRAME_CAP (FRAME_CAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata[7:0]),
      .out_pos   (rsp_tdata[15:8]),
      .out_last  (rsp_tlast),
      .out_cap   (rsp_tuser[0])
   );

   // A result past the cap always carries a zero byte.
   a_cap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0)
      else $error("capped result carries a nonzero byte");

   // The end of a frame never falls inside the header.
   a_last_after_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[15:8] >= 8'd3)
      else $error("frame end flagged on a header byte");

   // Position zero, when not capped, is always the first sync byte.
   a_pos0_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:8] == 8'd0 && !rsp_tuser[0]
      |-> rsp_tdata[7:0] == hlfd_pkg::SYNC_FIRST)
      else $error("position zero is not the sync byte");

endmodule

`default_nettype wire

[tb/sv/header_length_frame_deframer_checker.sv]
`timescale 1ns / 1ps
// Checker for the header/length frame deframer: watches both streams, predicts each result
// from the accepted input bytes and compares it field by field. Depends on hlfd_pkg.
module header_length_frame_deframer_checker #(
   parameter int BUF_SIZE  = hlfd_pkg::BUF_SIZE_DEFAULT,
   parameter int FRAME_CAP = hlfd_pkg::FRAME_CAP_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] restart
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [7:0] out_byte, [15:8] byte_pos
   input  wire logic        rsp_tlast,   // frame_last
   input  wire logic [0:0]  rsp_tuser,   // [0] beyond_cap
   output int               mismatch_count,
   output int               pending_count
);
   import hlfd_pkg::*;

   localparam int MAX_REPORTS = 20;

   typedef enum logic [1:0] {
      SEEK_FIRST,
      SEEK_SECOND,
      SEEK_LENGTH,
      IN_PAYLOAD
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] pos;
      logic       last;
      logic       cap;
   } frame_byte_type;

   parse_state_type parse_state = SEEK_FIRST;
   logic [8:0]      seen_count  = '0;
   logic [8:0]      frame_len   = '0;
   frame_byte_type  pending_bytes[$];
   int              errors      = 0;

   function automatic frame_byte_type make_frame_byte(logic [7:0] data, logic [7:0] pos,
                                                      logic last);
      frame_byte_type fb;
      fb.cap  = (int'(pos) >= FRAME_CAP);
      fb.data = fb.cap ? 8'h00 : data;
      fb.pos  = pos;
      fb.last = last;
      return fb;
   endfunction

   function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got)
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
   endfunction

   // Advances the parser by one accepted input transfer and queues the results it causes.
   task automatic advance_parser(input logic [7:0] rx, input logic rs);
      logic [8:0] pos;
      logic       last;
      if (rs) begin
         parse_state = SEEK_FIRST;
         seen_count  = '0;
      end else begin
         case (parse_state)
            SEEK_FIRST: begin
               if (rx == SYNC_FIRST) begin
                  seen_count  = 9'd1;
                  parse_state = SEEK_SECOND;
               end
            end
            SEEK_SECOND: begin
               if (rx == SYNC_SECOND) begin
                  seen_count  = 9'd2;
                  parse_state = SEEK_LENGTH;
               end else if (rx == SYNC_FIRST) begin
                  seen_count = 9'd1;
               end else begin
                  seen_count  = '0;
                  parse_state = SEEK_FIRST;
               end
            end
            SEEK_LENGTH: begin
               if (rx >= 8'd1 && int'(rx) <= BUF_SIZE - 3) begin
                  frame_len   = HEADER_LEN + {1'b0, rx};
                  seen_count  = HEADER_LEN;
                  parse_state = IN_PAYLOAD;
                  pending_bytes.push_back(make_frame_byte(SYNC_FIRST, 8'd0, 1'b0));
                  pending_bytes.push_back(make_frame_byte(SYNC_SECOND, 8'd1, 1'b0));
                  pending_bytes.push_back(make_frame_byte(rx, 8'd2, 1'b0));
               end else begin
                  seen_count  = '0;
                  parse_state = SEEK_FIRST;
               end
            end
            default: begin
               pos        = seen_count;
               seen_count = seen_count + 9'd1;
               last       = (seen_count >= frame_len);
               pending_bytes.push_back(make_frame_byte(rx, pos[7:0], last));
               if (last) begin
                  parse_state = SEEK_FIRST;
                  seen_count  = '0;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      frame_byte_type want;
      frame_byte_type got;
      if (reset) begin
         parse_state = SEEK_FIRST;
         seen_count  = '0;
         frame_len   = '0;
         pending_bytes.delete();
      end else begin
         // Results are checked before the input transfer of the same edge is predicted;
         // the block cannot answer an input in the cycle it accepts it.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser[0]};
            if (pending_bytes.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none actual %h", $realtime, got);
            end else begin
               want = pending_bytes.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     report_field("out_byte", want.data, got.data);
                     report_field("byte_pos", want.pos, got.pos);
                     report_field("frame_last", {7'd0, want.last}, {7'd0, got.last});
                     report_field("beyond_cap", {7'd0, want.cap}, {7'd0, got.cap});
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_parser(req_tdata, req_tuser[0]);
      end
      mismatch_count <= errors;
      pending_count  <= pending_bytes.size();
   end

endmodule

[tb/sv/header_length_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the header/length frame deframer: clock, reset, byte stimulus with
// random idling on both sides, and the verdict. Depends on hlfd_pkg and the checker module.
module header_length_frame_deframer_tb;
   import hlfd_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_LEN      = BUF_SIZE_DEFAULT - 3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic [0:0]  req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   int mismatches;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;
   int cycles    = 0;

   always #2 clock = ~clock;

   header_length_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   header_length_frame_deframer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Presents one byte and holds it until the transfer completes.
   task automatic send_item(input logic [7:0] rx, input logic rs);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= rs;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent++;
   endtask

   // Sync pair, length and payload; a restart replaces payload byte cut when cut < len.
   task automatic send_frame(input logic [7:0] len, input int cut);
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(len, 1'b0);
      for (int i = 0; i < int'(len); i++) begin
         if (i == cut) begin
            send_item(8'($urandom_range(255)), 1'b1);
            break;
         end
         send_item(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // Mostly short frames so that the run stays fast, now and then a long or maximal one.
   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 3)
         return 8'(MAX_LEN);
      else if (r < 10)
         return 8'($urandom_range(MAX_LEN - 1, 13));
      return 8'($urandom_range(12, 1));
   endfunction

   initial begin
      int r;
      int base;
      int phase_idle;
      int phase_stall;
      int cut;
      bit quiet;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Restart while hunting, with and without a sync byte on the data lines.
      send_item(8'h00, 1'b1);
      send_item(SYNC_FIRST, 1'b1);
      send_item(8'hFF, 1'b0);
      // A repeated first sync byte restarts the pair; shortest frame.
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hAA, 1'b0);
      // Broken sync pair falls back to the hunt.
      send_item(SYNC_FIRST, 1'b0);
      send_item(8'h00, 1'b0);
      // Length zero and length just above the limit drop the frame.
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(8'(MAX_LEN + 1), 1'b0);
      // Restart in the middle of a payload that carries a sync byte.
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(SYNC_FIRST, 1'b0);
      send_item(8'h55, 1'b1);
      send_item(SYNC_FIRST, 1'b0);
      send_item(SYNC_SECOND, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hFF, 1'b0);

      base = sent;
      send_frame(8'(MAX_LEN), MAX_LEN);
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin phase_idle = 0;  phase_stall = 0;  end
            1: begin phase_idle = 62; phase_stall = 0;  end
            2: begin phase_idle = 0;  phase_stall = 62; end
            default: begin phase_idle = 30; phase_stall = 30; end
         endcase
         while (sent < base + RANDOM_ITEMS * (p + 1) / 4) begin
            quiet     = ($urandom_range(7) == 0);
            idle_pct  = quiet ? 0 : phase_idle;
            stall_pct = quiet ? 0 : phase_stall;
            r = $urandom_range(99);
            if (r < 70) begin
               cut = ($urandom_range(99) < 5) ? 0 : 256;
               if (cut == 0)
                  cut = $urandom_range(12);
               send_frame(pick_length(), cut);
            end else if (r < 78) begin
               send_item(SYNC_FIRST, 1'b0);
               repeat ($urandom_range(2)) send_item(SYNC_FIRST, 1'b0);
               if ($urandom_range(1))
                  send_frame(pick_length(), 256);
               else
                  send_item(8'($urandom_range(255)), 1'b0);
            end else if (r < 86) begin
               send_item(SYNC_FIRST, 1'b0);
               send_item(SYNC_SECOND, 1'b0);
               if ($urandom_range(1))
                  send_item(8'h00, 1'b0);
               else
                  send_item(8'($urandom_range(255, MAX_LEN + 1)), 1'b0);
            end else if (r < 93) begin
               send_item(8'($urandom_range(255)), 1'b0);
            end else begin
               send_item(8'($urandom_range(255)), 1'b1);
            end
         end
      end
      req_tvalid <= 1'b0;

      // The pending count is registered in the checker, so it lags the transfers.
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
